// File: hdl/acb_pkg.sv
`default_nettype none

package acb_pkg;

	// fixed field widths
	localparam int REG_W     = 13;
	localparam int CFG_IDX_W = 3;
	localparam int CHAN_W    = 8;
	localparam int ADDR_W    = 24;
	localparam int SUM_W     = 2 * CHAN_W;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEST_WIDTH  = 3'd0,
		REG_DEST_HEIGHT = 3'd1,
		REG_TOP_WIDTH   = 3'd2,
		REG_TOP_HEIGHT  = 3'd3,
		REG_PLACE_X     = 3'd4,
		REG_PLACE_Y     = 3'd5
	} cfg_reg_t;

	// one color triple
	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgb_t;

	// (d*(255-a) + t*a) / 255, truncated; the sum stays below 2^16 so the
	// divide by 255 is exact as (x + 1 + (x >> 8)) >> 8
	function automatic logic [CHAN_W-1:0] blend(
		input logic [CHAN_W-1:0] d,
		input logic [CHAN_W-1:0] t,
		input logic [CHAN_W-1:0] a
	);
		logic [CHAN_W-1:0] inv;
		logic [SUM_W-1:0]  x;
		logic [SUM_W:0]    q;
		inv = ~a;
		x   = SUM_W'(d * inv) + SUM_W'(t * a);
		q   = {1'b0, x} + (SUM_W+1)'(1) + (SUM_W+1)'(x >> CHAN_W);
		return q[SUM_W-1:CHAN_W];
	endfunction

endpackage

`default_nettype wire

// File: hdl/alpha_compose_blit.sv
// alpha_compose_blit: blends a top image over a destination image
// pipeline: an accepted pixel pair passes through the input stage and then the result register
// throughput: one pixel pair per cycle; in_ready drops only while both the
// input stage and the result register hold requests that cannot advance
// reset: arst_n clears the configuration registers, the raster counters and both valid bits
`default_nettype none

module alpha_compose_blit #(
	parameter int MAX_DIM = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         cfg_write,
	input  logic [acb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [acb_pkg::REG_W-1:0]    cfg_data,

	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [acb_pkg::CHAN_W-1:0]   top_red,
	input  logic [acb_pkg::CHAN_W-1:0]   top_green,
	input  logic [acb_pkg::CHAN_W-1:0]   top_blue,
	input  logic [acb_pkg::CHAN_W-1:0]   top_alpha,
	input  logic [acb_pkg::CHAN_W-1:0]   dest_red,
	input  logic [acb_pkg::CHAN_W-1:0]   dest_green,
	input  logic [acb_pkg::CHAN_W-1:0]   dest_blue,

	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [acb_pkg::CHAN_W-1:0]   out_red,
	output logic [acb_pkg::CHAN_W-1:0]   out_green,
	output logic [acb_pkg::CHAN_W-1:0]   out_blue,
	output logic [acb_pkg::ADDR_W-1:0]   dest_address,
	output logic [acb_pkg::ADDR_W-1:0]   top_address,
	output logic                         is_last,
	output logic                         clipped
);
	import acb_pkg::*;

	localparam int CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int OVL_W = $clog2(MAX_DIM + 1);
	localparam int CMP_W = ((OVL_W > REG_W) ? OVL_W : REG_W) + 1;

	// configuration registers
	logic [REG_W-1:0] dest_width_q, dest_height_q;
	logic [REG_W-1:0] top_width_q, top_height_q;
	logic [REG_W-1:0] place_x_q, place_y_q;

	// raster counters
	logic [CNT_W-1:0] col_q, row_q;

	// input stage
	logic             valid_s1;
	rgb_t             top_s1, dest_s1;
	logic [CHAN_W-1:0] alpha_s1;
	logic [CNT_W-1:0] col_s1, row_s1;
	logic             last_s1, clip_s1;

	// result stage
	logic             valid_s2;
	rgb_t             color_s2;
	logic [ADDR_W-1:0] dest_addr_s2, top_addr_s2;
	logic             last_s2, clip_s2;

	logic             adv_s2, accept, cfg_hit;
	logic [OVL_W-1:0] ovl_w, ovl_h;
	logic             empty, last_col, last_row;

	// clipped overlap in one direction
	function automatic logic [OVL_W-1:0] overlap(
		input logic [REG_W-1:0] dest,
		input logic [REG_W-1:0] pos,
		input logic [REG_W-1:0] top
	);
		logic [REG_W-1:0] d;
		d = dest - pos;
		if (pos >= dest) begin
			d = '0;
		end
		if (d > top) begin
			d = top;
		end
		if (CMP_W'(d) > CMP_W'(MAX_DIM)) begin
			return OVL_W'(MAX_DIM);
		end
		return OVL_W'(d);
	endfunction

	// handshake
	assign adv_s2   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s2;
	assign accept   = in_valid && in_ready;

	// overlap and end-of-row/frame detection
	always_comb begin
		ovl_w    = overlap(dest_width_q, place_x_q, top_width_q);
		ovl_h    = overlap(dest_height_q, place_y_q, top_height_q);
		empty    = (ovl_w == '0) || (ovl_h == '0);
		last_col = (CMP_W'(col_q) + CMP_W'(1)) >= CMP_W'(ovl_w);
		last_row = (CMP_W'(row_q) + CMP_W'(1)) >= CMP_W'(ovl_h);
	end

	// register index decode
	always_comb begin
		case (cfg_index)
			REG_DEST_WIDTH, REG_DEST_HEIGHT, REG_TOP_WIDTH,
			REG_TOP_HEIGHT, REG_PLACE_X, REG_PLACE_Y: cfg_hit = 1'b1;
			default: cfg_hit = 1'b0;
		endcase
	end

	// configuration, counters and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_width_q  <= '0;
			dest_height_q <= '0;
			top_width_q   <= '0;
			top_height_q  <= '0;
			place_x_q     <= '0;
			place_y_q     <= '0;
			col_q         <= '0;
			row_q         <= '0;
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_DEST_WIDTH:  dest_width_q  <= cfg_data;
					REG_DEST_HEIGHT: dest_height_q <= cfg_data;
					REG_TOP_WIDTH:   top_width_q   <= cfg_data;
					REG_TOP_HEIGHT:  top_height_q  <= cfg_data;
					REG_PLACE_X:     place_x_q     <= cfg_data;
					REG_PLACE_Y:     place_y_q     <= cfg_data;
					default: ;
				endcase
			end
			if (cfg_write && cfg_hit) begin
				col_q <= '0;
				row_q <= '0;
			end else if (accept && !empty) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + CNT_W'(1);
				end else begin
					col_q <= col_q + CNT_W'(1);
				end
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			top_s1   <= '{red: top_red, green: top_green, blue: top_blue};
			dest_s1  <= '{red: dest_red, green: dest_green, blue: dest_blue};
			alpha_s1 <= top_alpha;
			col_s1   <= col_q;
			row_s1   <= row_q;
			last_s1  <= !empty && last_col && last_row;
			clip_s1  <= empty;
		end
	end

	// blend and address arithmetic into the result register
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			last_s2 <= last_s1;
			clip_s2 <= clip_s1;
			if (clip_s1) begin
				color_s2     <= dest_s1;
				dest_addr_s2 <= '0;
				top_addr_s2  <= '0;
			end else begin
				color_s2.red   <= blend(dest_s1.red, top_s1.red, alpha_s1);
				color_s2.green <= blend(dest_s1.green, top_s1.green, alpha_s1);
				color_s2.blue  <= blend(dest_s1.blue, top_s1.blue, alpha_s1);
				dest_addr_s2   <= (ADDR_W'(place_y_q) + ADDR_W'(row_s1))
					* ADDR_W'(dest_width_q) + ADDR_W'(place_x_q) + ADDR_W'(col_s1);
				top_addr_s2    <= ADDR_W'(row_s1) * ADDR_W'(top_width_q)
					+ ADDR_W'(col_s1);
			end
		end
	end

	// outputs
	assign out_valid    = valid_s2;
	assign out_red      = color_s2.red;
	assign out_green    = color_s2.green;
	assign out_blue     = color_s2.blue;
	assign dest_address = dest_addr_s2;
	assign top_address  = top_addr_s2;
	assign is_last      = last_s2;
	assign clipped      = clip_s2;

	// a clipped request carries no addresses and no end flag
	a_clip_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |-> !is_last && dest_address == '0 && top_address == '0)
		else $error("clipped request with nonzero addresses or end flag");

	// an empty result register never stalls the input side
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	// a request waiting for out_ready holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(dest_address) && $stable(is_last))
		else $error("stalled result changed");

	// counters restart after the final pixel of the overlap
	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !empty && last_col && last_row && !cfg_write |=> col_q == '0 && row_q == '0)
		else $error("counters did not wrap after final pixel");

endmodule

`default_nettype wire
